[hw/rtl/lsc_pkg.sv]
package lsc_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_e;

  localparam int NUM_EDGES = 4;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Per-edge decision taken before the division
  typedef struct packed {
    logic                 rej;
    logic [NUM_EDGES-1:0] ent;
    logic [NUM_EDGES-1:0] ext;
  } edge_flags_t;

endpackage

[hw/rtl/lsc_div.sv]
// Restoring divider, one quotient bit per stage: quo = floor(num * 2^(QW-1) / den),
// for num <= den. Takes one word per cycle while en_i is high.
module lsc_div #(
  parameter int DW = 17,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW:0]   rem_q [QW-1];
  logic [DW-1:0] den_q [QW-1];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ge;
    logic [DW:0]   r_sub;

    if (s == 0) begin : g_first
      assign r_in = {1'b0, num_i};
      assign d_in = den_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign d_in = den_q[s-1];
      assign q_in = quo_q[s-1];
    end

    // Compare and subtract for this bit
    assign ge    = r_in >= {1'b0, d_in};
    assign r_sub = ge ? (r_in - {1'b0, d_in}) : r_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {q_in[QW-2:0], ge};
      end
    end

    if (s < QW - 1) begin : g_carry
      logic [DW:0] rem_d;
      assign rem_d = {r_sub[DW-1:0], 1'b0};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= d_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[hw/rtl/lsc_point.sv]
// Clipped coordinate: (a * 2^F + u * del) / 2^F truncated toward zero.
// Two stages: multiply, then add and round. Zero when keep_i is low.
module lsc_point #(
  parameter int C = 16,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                keep_i,
  input  logic signed [C-1:0] a_i,
  input  logic signed [C:0]   del_i,
  input  logic        [F:0]   u_i,
  output logic signed [C-1:0] pt_o
);

  localparam int PW = C + F + 3;
  localparam int TW = C + F + 4;

  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [C-1:0]  a_q;
  logic                 keep_q;
  logic signed [TW-1:0] sum;
  logic signed [TW-1:0] adj;
  logic signed [TW-1:0] shr;
  logic signed [C-1:0]  pt_d, pt_q;

  // Stage 1: multiply
  assign prod_d = PW'($signed({1'b0, u_i}) * del_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
      keep_q <= keep_i;
    end
  end

  // Stage 2: add, bias negatives, shift down
  assign sum  = $signed({{(F + 4){a_q[C-1]}}, a_q} <<< F) + TW'(prod_q);
  assign adj  = sum[TW-1] ? (sum + TW'((64'd1 << F) - 64'd1)) : sum;
  assign shr  = adj >>> F;
  assign pt_d = keep_q ? shr[C-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q <= pt_d;
    end
  end

  assign pt_o = pt_q;

endmodule

[hw/rtl/line_segment_window_clipper.sv]
// Line segment window clipper (Liang-Barsky).
// Input channel: one segment word per handshake (start_x/y, end_x/y), taken
// when in_valid_i and in_ready_o are high at a rising edge.
// Output channel: visible flag and clipped endpoints, handed over when
// out_valid_o and out_ready_i are high. A rejected segment gives visible 0 and
// zero coordinates.
// Window registers sit on an APB port at byte addresses 0, 4, 8, 12 (left, top,
// right, bottom); write them only while no segment is in flight.
// Path from accept to out_valid_o: input register, the four bit-per-stage
// dividers that form the edge ratios, the u1/u2 register, then the endpoint
// stages. Throughput: one segment per cycle while the output is not stalled.
// When the receiver stalls with a word waiting, every stage holds; in_ready_o
// is low until the waiting word is taken or the output stage is empty.
// Reset clears all valid bits and loads the window 100, 100, 300, 250.
module line_segment_window_clipper #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lsc_pkg::APB_AW-1:0]        paddr,
  input  logic [lsc_pkg::APB_DW-1:0]        pwdata,
  output logic [lsc_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              visible_o,
  output logic signed [COORD_BITS-1:0]      clip_start_x_o,
  output logic signed [COORD_BITS-1:0]      clip_start_y_o,
  output logic signed [COORD_BITS-1:0]      clip_end_x_o,
  output logic signed [COORD_BITS-1:0]      clip_end_y_o
);

  localparam int C  = COORD_BITS;
  localparam int W  = C + 2;
  localparam int DW = C + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int NE = lsc_pkg::NUM_EDGES;
  localparam int SD = QW + 1;

  // Window registers
  logic signed [C-1:0] left_q, top_q, right_q, bottom_q;
  logic                wr_en;
  lsc_pkg::reg_idx_e   wr_idx;
  logic signed [C-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_idx = lsc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= C'(100);
      top_q    <= C'(100);
      right_q  <= C'(300);
      bottom_q <= C'(250);
    end else if (wr_en) begin
      case (wr_idx)
        lsc_pkg::REG_LEFT:   left_q   <= pwdata[C-1:0];
        lsc_pkg::REG_TOP:    top_q    <= pwdata[C-1:0];
        lsc_pkg::REG_RIGHT:  right_q  <= pwdata[C-1:0];
        lsc_pkg::REG_BOTTOM: bottom_q <= pwdata[C-1:0];
        default: ;
      endcase
    end
  end

  // Read back, sign extended
  always_comb begin
    case (wr_idx)
      lsc_pkg::REG_LEFT:   rd_val = left_q;
      lsc_pkg::REG_TOP:    rd_val = top_q;
      lsc_pkg::REG_RIGHT:  rd_val = right_q;
      lsc_pkg::REG_BOTTOM: rd_val = bottom_q;
      default:             rd_val = '0;
    endcase
  end
  assign prdata = lsc_pkg::APB_DW'(rd_val);

  // Pipeline advance: hold everything while the output word waits
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;

  // Stage 0: edge terms and classification
  logic signed [W-1:0] x1, y1, x2, y2;
  logic signed [W-1:0] p_c [NE];
  logic signed [W-1:0] q_c [NE];
  logic signed [W-1:0] n_c [NE];
  logic signed [W-1:0] d_c [NE];
  lsc_pkg::edge_flags_t fl_c;

  assign x1 = W'(start_x_i);
  assign y1 = W'(start_y_i);
  assign x2 = W'(end_x_i);
  assign y2 = W'(end_y_i);

  always_comb begin
    p_c[0] = x1 - x2;  q_c[0] = x1 - W'(left_q);
    p_c[1] = x2 - x1;  q_c[1] = W'(right_q) - x1;
    p_c[2] = y1 - y2;  q_c[2] = y1 - W'(top_q);
    p_c[3] = y2 - y1;  q_c[3] = W'(bottom_q) - y1;
    fl_c = '0;
    for (int i = 0; i < NE; i++) begin
      if (p_c[i] < 0) begin
        n_c[i] = -q_c[i];
        d_c[i] = -p_c[i];
      end else begin
        n_c[i] = q_c[i];
        d_c[i] = p_c[i];
      end
      if (p_c[i] == 0) begin
        if (q_c[i] < 0) fl_c.rej = 1'b1;
      end else if (p_c[i] < 0) begin
        if (n_c[i] > d_c[i]) fl_c.rej = 1'b1;
        else if (n_c[i] >= 0) fl_c.ent[i] = 1'b1;
      end else begin
        if (n_c[i] < 0) fl_c.rej = 1'b1;
        else if (n_c[i] <= d_c[i]) fl_c.ext[i] = 1'b1;
      end
    end
  end

  // Sideband line alongside the dividers
  logic                 vld_q [SD];
  logic signed [C-1:0]  sx_q  [SD];
  logic signed [C-1:0]  sy_q  [SD];
  logic signed [C:0]    dx_q  [SD];
  logic signed [C:0]    dy_q  [SD];
  lsc_pkg::edge_flags_t fl_q  [SD];
  logic [DW-1:0]        num_q [NE];
  logic [DW-1:0]        den_q [NE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SD; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < SD; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q[0] <= start_x_i;
      sy_q[0] <= start_y_i;
      dx_q[0] <= x2[C:0] - x1[C:0];
      dy_q[0] <= y2[C:0] - y1[C:0];
      fl_q[0] <= fl_c;
      for (int i = 0; i < NE; i++) begin
        num_q[i] <= n_c[i][DW-1:0];
        den_q[i] <= d_c[i][DW-1:0];
      end
      for (int s = 1; s < SD; s++) begin
        sx_q[s] <= sx_q[s-1];
        sy_q[s] <= sy_q[s-1];
        dx_q[s] <= dx_q[s-1];
        dy_q[s] <= dy_q[s-1];
        fl_q[s] <= fl_q[s-1];
      end
    end
  end

  // Edge ratios
  logic [QW-1:0] ratio [NE];
  for (genvar i = 0; i < NE; i++) begin : g_div
    lsc_div #(.DW(DW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i (den_q[i]),
      .quo_o (ratio[i])
    );
  end

  // Tighten u1 and u2, final reject
  logic [QW-1:0]       u1_d, u2_d, u1_q, u2_q;
  logic                keep_d, keep_q, vm_q;
  logic signed [C-1:0] mx_q, my_q;
  logic signed [C:0]   mdx_q, mdy_q;
  lsc_pkg::edge_flags_t fl_l;

  assign fl_l = fl_q[SD-1];

  always_comb begin
    u1_d = '0;
    u2_d = QW'(1) << FRAC_BITS;
    for (int i = 0; i < NE; i++) begin
      if (fl_l.ent[i] && ratio[i] > u1_d) u1_d = ratio[i];
      if (fl_l.ext[i] && ratio[i] < u2_d) u2_d = ratio[i];
    end
    keep_d = !fl_l.rej && !(u1_d > u2_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= vld_q[SD-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q   <= u1_d;
      u2_q   <= u2_d;
      keep_q <= keep_d;
      mx_q   <= sx_q[SD-1];
      my_q   <= sy_q[SD-1];
      mdx_q  <= dx_q[SD-1];
      mdy_q  <= dy_q[SD-1];
    end
  end

  // Endpoint arithmetic, two stages
  logic vp_q, vis_p_q, vis_q;

  lsc_point #(.C(C), .F(FRAC_BITS)) u_sx (
    .clk_i(clk_i), .en_i(en), .keep_i(keep_q), .a_i(mx_q), .del_i(mdx_q),
    .u_i(u1_q), .pt_o(clip_start_x_o)
  );
  lsc_point #(.C(C), .F(FRAC_BITS)) u_sy (
    .clk_i(clk_i), .en_i(en), .keep_i(keep_q), .a_i(my_q), .del_i(mdy_q),
    .u_i(u1_q), .pt_o(clip_start_y_o)
  );
  lsc_point #(.C(C), .F(FRAC_BITS)) u_ex (
    .clk_i(clk_i), .en_i(en), .keep_i(keep_q), .a_i(mx_q), .del_i(mdx_q),
    .u_i(u2_q), .pt_o(clip_end_x_o)
  );
  lsc_point #(.C(C), .F(FRAC_BITS)) u_ey (
    .clk_i(clk_i), .en_i(en), .keep_i(keep_q), .a_i(my_q), .del_i(mdy_q),
    .u_i(u2_q), .pt_o(clip_end_y_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vp_q        <= vm_q;
      out_valid_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vis_p_q <= keep_q;
      vis_q   <= vis_p_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign visible_o   = vis_q;

endmodule

[hw/rtl/lsc_checker.sv]
module lsc_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic                   visible_o,
  input logic [COORD_BITS-1:0]  clip_start_x_o,
  input logic [COORD_BITS-1:0]  clip_start_y_o,
  input logic [COORD_BITS-1:0]  clip_end_x_o,
  input logic [COORD_BITS-1:0]  clip_end_y_o
);

  // Hold a stalled output word
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(visible_o)
      && $stable(clip_start_x_o) && $stable(clip_end_y_o))
    else $error("stalled output word changed");

  // Rejected words carry zero coordinates
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> clip_start_x_o == '0 && clip_start_y_o == '0
      && clip_end_x_o == '0 && clip_end_y_o == '0)
    else $error("rejected word has nonzero coordinates");

  // Input is taken whenever the output stage can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("in_ready_o does not follow the output stage");

  // Nothing leaves right after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid coming out of reset");

endmodule

bind line_segment_window_clipper lsc_checker #(.COORD_BITS(COORD_BITS)) u_lsc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .visible_o      (visible_o),
  .clip_start_x_o (clip_start_x_o),
  .clip_start_y_o (clip_start_y_o),
  .clip_end_x_o   (clip_end_x_o),
  .clip_end_y_o   (clip_end_y_o)
);
